>>> sv/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg: shared types and constants for the fragment deframer
// Phase and result-kind codes, register indexes, the result record and the
// bytewise reflected CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package cdf_pkg;

  localparam int unsigned MARKER_MAX_BYTES = 4;
  // Usable marker length: the window holds at most four bytes.
  localparam int unsigned MARKER_CAP = (MARKER_MAX_BYTES < 4) ? MARKER_MAX_BYTES : 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Control byte bits.
  localparam int unsigned CTRL_CONT_BIT = 0;
  localparam int unsigned CTRL_LAST_BIT = 1;

  // Fragment header: 8 bytes of total length, then 4 bytes of CRC.
  localparam logic [3:0] HDR_CRC_START = 4'd8;
  localparam logic [3:0] HDR_BYTES     = 4'd12;

  // Configuration register indexes.
  localparam logic [1:0] REG_MARKER_VALUE = 2'd0;
  localparam logic [1:0] REG_MARKER_LEN   = 2'd1;
  localparam logic [1:0] REG_TYPE_MASK    = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_CTRL,
    PH_HDR,
    PH_LEN,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_EMPTY_END = 2'd1,
    KIND_SHORT     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] marker_value;
    logic [2:0]  marker_length;
    logic [63:0] header_type_mask;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] query_type;
    logic [7:0] data_byte;
    logic       first_fragment;
    logic       end_of_message;
    logic       crc_ok;
  } result_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Marker length clamped to 1..MARKER_CAP.
  function automatic logic [2:0] marker_len_eff(input logic [2:0] len);
    logic [2:0] n;
    n = len;
    if (n == 3'd0) begin
      n = 3'd1;
    end
    if (n > MARKER_CAP[2:0]) begin
      n = MARKER_CAP[2:0];
    end
    return n;
  endfunction

  function automatic logic [31:0] marker_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> sv/crc32_fragment_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// crc32_fragment_packet_deframer_core: marker-framed fragment deframer
// Hunts a configurable start marker, parses type, control, header and length
// fields, emits payload bytes and checks the message CRC-32.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while its input is ready and gives
// at most one result beat per byte. A byte is captured in an input register and
// parsed once the output register can take its outcome, the bytewise CRC-32 update
// being the deepest logic, and its result lands in the output register. Input ready
// stays high while the output register is empty or being drained, so with the
// downstream side always ready the throughput is one byte per clock. The user must
// write configuration only while no byte is in flight; the block does not enforce it.
`default_nettype none

module crc32_fragment_packet_deframer_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,    // rx_byte
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [23:0]        m_tdata,    // query_type, data_byte, first_fragment, crc_ok, zeros
  output logic               m_tlast,    // end_of_message
  output logic [1:0]         m_tuser,    // result_kind
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [63:0]   cfg_data
);

  cdf_pkg::cfg_t    cfg;
  cdf_pkg::result_t res;
  logic             res_valid;
  logic             in_valid;
  logic [7:0]       in_byte;
  logic             step;

  // The held byte is parsed once the result register can take its outcome.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  cdf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cdf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  cdf_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && res_valid),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

>>> sv/cdf_cfg_regs.sv
// ----------------------------------------------------------------------------
// cdf_cfg_regs: configuration register file
// Holds the start marker, its length and the header type mask.
// ----------------------------------------------------------------------------
`default_nettype none

module cdf_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [63:0]   cfg_data,
  output cdf_pkg::cfg_t      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.marker_value     <= '0;
      cfg.marker_length    <= 3'd1;
      cfg.header_type_mask <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cdf_pkg::REG_MARKER_VALUE: cfg.marker_value     <= cfg_data[31:0];
        cdf_pkg::REG_MARKER_LEN:   cfg.marker_length    <= cfg_data[2:0];
        cdf_pkg::REG_TYPE_MASK:    cfg.header_type_mask <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/cdf_parser.sv
// ----------------------------------------------------------------------------
// cdf_parser: deframing state machine
// Consumes one byte per step, tracks marker hunt, header fields, payload
// length and running CRC, and produces at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cdf_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    rx_byte,
  input  wire cdf_pkg::cfg_t cfg,
  output logic               res_valid,
  output cdf_pkg::result_t   res
);

  cdf_pkg::phase_t phase, phase_next;
  logic [31:0] marker_window, marker_window_next;
  logic [2:0]  window_fill, window_fill_next;
  logic [7:0]  current_type, current_type_next;
  logic [1:0]  fragment_flags, fragment_flags_next;
  logic [3:0]  field_count, field_count_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [31:0] expected_crc, expected_crc_next;
  logic [31:0] crc_running, crc_running_next;

  logic [2:0]  mlen;
  logic [31:0] mmask;
  logic [31:0] window_shift;
  logic [2:0]  fill_inc;
  logic        marker_hit;
  logic        type_has_hdr;
  logic        len_zero;
  logic [15:0] bytes_dec;
  logic [31:0] crc_upd;
  logic [3:0]  field_inc;

  assign mlen         = cdf_pkg::marker_len_eff(cfg.marker_length);
  assign mmask        = cdf_pkg::marker_mask(mlen);
  assign window_shift = {marker_window[23:0], rx_byte};
  assign fill_inc     = (window_fill < 3'd4) ? window_fill + 3'd1 : window_fill;
  assign marker_hit   = (fill_inc >= mlen) &&
                        ((window_shift & mmask) == (cfg.marker_value & mmask));
  assign type_has_hdr = (rx_byte[7:6] == 2'b00) && cfg.header_type_mask[rx_byte[5:0]];
  assign len_zero     = ({rx_byte, bytes_left[7:0]} == 16'd0);
  assign bytes_dec    = bytes_left - 16'd1;
  assign crc_upd      = cdf_pkg::crc32_byte(crc_running, rx_byte);
  assign field_inc    = field_count + 4'd1;

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      cdf_pkg::PH_HUNT: phase_next = marker_hit ? cdf_pkg::PH_TYPE : cdf_pkg::PH_HUNT;
      cdf_pkg::PH_TYPE: phase_next = type_has_hdr ? cdf_pkg::PH_CTRL : cdf_pkg::PH_HUNT;
      cdf_pkg::PH_CTRL: phase_next = rx_byte[cdf_pkg::CTRL_CONT_BIT] ? cdf_pkg::PH_LEN
                                                                   : cdf_pkg::PH_HDR;
      cdf_pkg::PH_HDR:  phase_next = (field_inc >= cdf_pkg::HDR_BYTES) ? cdf_pkg::PH_LEN
                                                                       : cdf_pkg::PH_HDR;
      cdf_pkg::PH_LEN: begin
        if (field_count == 4'd0) begin
          phase_next = cdf_pkg::PH_LEN;
        end else begin
          phase_next = len_zero ? cdf_pkg::PH_HUNT : cdf_pkg::PH_DATA;
        end
      end
      cdf_pkg::PH_DATA: phase_next = (bytes_dec == 16'd0) ? cdf_pkg::PH_HUNT : cdf_pkg::PH_DATA;
      default:          phase_next = cdf_pkg::PH_HUNT;
    endcase
  end

  // Datapath updates and result.
  always_comb begin
    marker_window_next  = marker_window;
    window_fill_next    = window_fill;
    current_type_next   = current_type;
    fragment_flags_next = fragment_flags;
    field_count_next    = field_count;
    bytes_left_next     = bytes_left;
    expected_crc_next   = expected_crc;
    crc_running_next    = crc_running;
    res_valid           = 1'b0;
    res                 = '0;
    res.query_type      = current_type;
    case (phase)
      cdf_pkg::PH_HUNT: begin
        if (marker_hit) begin
          marker_window_next = '0;
          window_fill_next   = '0;
        end else begin
          marker_window_next = window_shift;
          window_fill_next   = fill_inc;
        end
      end
      cdf_pkg::PH_TYPE: begin
        current_type_next = rx_byte;
        if (!type_has_hdr) begin
          res_valid          = 1'b1;
          res.kind           = cdf_pkg::KIND_SHORT;
          res.query_type     = rx_byte;
          marker_window_next = '0;
          window_fill_next   = '0;
        end
      end
      cdf_pkg::PH_CTRL: begin
        fragment_flags_next = rx_byte[1:0];
        field_count_next    = '0;
        if (!rx_byte[cdf_pkg::CTRL_CONT_BIT]) begin
          crc_running_next = cdf_pkg::CRC_INIT;
        end
      end
      cdf_pkg::PH_HDR: begin
        if (field_count >= cdf_pkg::HDR_CRC_START) begin
          case (field_count[1:0])
            2'd0:    expected_crc_next[7:0]   = rx_byte;
            2'd1:    expected_crc_next[15:8]  = rx_byte;
            2'd2:    expected_crc_next[23:16] = rx_byte;
            default: expected_crc_next[31:24] = rx_byte;
          endcase
        end
        field_count_next = (field_inc >= cdf_pkg::HDR_BYTES) ? 4'd0 : field_inc;
      end
      cdf_pkg::PH_LEN: begin
        if (field_count == 4'd0) begin
          bytes_left_next  = {8'd0, rx_byte};
          field_count_next = 4'd1;
        end else begin
          bytes_left_next  = {rx_byte, bytes_left[7:0]};
          field_count_next = '0;
          if (len_zero) begin
            marker_window_next = '0;
            window_fill_next   = '0;
            // An empty last fragment still closes the message.
            if (fragment_flags[cdf_pkg::CTRL_LAST_BIT]) begin
              res_valid          = 1'b1;
              res.kind           = cdf_pkg::KIND_EMPTY_END;
              res.first_fragment = !fragment_flags[cdf_pkg::CTRL_CONT_BIT];
              res.end_of_message = 1'b1;
              res.crc_ok         = (~crc_running == expected_crc);
            end
          end
        end
      end
      cdf_pkg::PH_DATA: begin
        crc_running_next   = crc_upd;
        bytes_left_next    = bytes_dec;
        res_valid          = 1'b1;
        res.kind           = cdf_pkg::KIND_DATA;
        res.data_byte      = rx_byte;
        res.first_fragment = !fragment_flags[cdf_pkg::CTRL_CONT_BIT];
        res.end_of_message = (bytes_dec == 16'd0) && fragment_flags[cdf_pkg::CTRL_LAST_BIT];
        res.crc_ok         = res.end_of_message && (~crc_upd == expected_crc);
        if (bytes_dec == 16'd0) begin
          marker_window_next = '0;
          window_fill_next   = '0;
        end
      end
      default: begin
        marker_window_next = '0;
        window_fill_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= cdf_pkg::PH_HUNT;
      marker_window  <= '0;
      window_fill    <= '0;
      current_type   <= '0;
      fragment_flags <= '0;
      field_count    <= '0;
      bytes_left     <= '0;
      expected_crc   <= '0;
      crc_running    <= cdf_pkg::CRC_INIT;
    end else if (step) begin
      phase          <= phase_next;
      marker_window  <= marker_window_next;
      window_fill    <= window_fill_next;
      current_type   <= current_type_next;
      fragment_flags <= fragment_flags_next;
      field_count    <= field_count_next;
      bytes_left     <= bytes_left_next;
      expected_crc   <= expected_crc_next;
      crc_running    <= crc_running_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/cdf_out_reg.sv
// ----------------------------------------------------------------------------
// cdf_out_reg: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cdf_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire cdf_pkg::result_t res,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [23:0]           m_tdata,   // query_type, data_byte, first_fragment, crc_ok, zeros
  output logic                  m_tlast,   // end_of_message
  output logic [1:0]            m_tuser    // result_kind
);

  cdf_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {6'd0, held.crc_ok, held.first_fragment, held.data_byte, held.query_type};
  assign m_tlast = held.end_of_message;
  assign m_tuser = held.kind;

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for crc32_fragment_packet_deframer_core
// A short scripted sequence covers the marker hunt, headerless queries, empty
// and payload fragments and the length clamp, then randomly configured phases
// send marker-framed messages, some corrupted, cut short or mixed with noise.
// Every byte taken by the block is run through a local deframer model, and
// each result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RANDOM_BYTES   = 1600;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 300;

  typedef struct {
    bit                is_cfg;
    logic [7:0]        rx;
    bit                has_want;
    cdf_pkg::result_t  want;
    logic [31:0]       mv;
    logic [2:0]        ml;
    logic [63:0]       tm;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  crc32_fragment_packet_deframer_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model copy of the registers.
  logic [31:0] marker_value_q = 32'd0;
  logic [2:0]  marker_len_q   = 3'd1;
  logic [63:0] type_mask_q    = 64'd0;

  // Model copy of the parser state.
  cdf_pkg::phase_t parse_phase = cdf_pkg::PH_HUNT;
  logic [31:0] hunt_window   = 32'd0;
  logic [2:0]  hunt_fill     = 3'd0;
  logic [7:0]  cur_type      = 8'd0;
  logic [1:0]  frag_flags    = 2'd0;
  logic [3:0]  hdr_count     = 4'd0;
  logic [15:0] payload_left  = 16'd0;
  logic [31:0] header_crc    = 32'd0;
  logic [31:0] running_crc   = cdf_pkg::CRC_INIT;

  cdf_pkg::result_t deframed_due[$];
  script_row_t script[$];
  int          mismatch_count = 0;
  int          random_items = 0;
  int          tick_count = 0;
  wire         calm = ((tick_count / 700) % 4) == 2;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) tick_count <= tick_count + 1;

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ cdf_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic int marker_bytes();
    int n;
    n = int'(marker_len_q);
    if (n < 1) n = 1;
    if (n > int'(cdf_pkg::MARKER_CAP)) n = int'(cdf_pkg::MARKER_CAP);
    return n;
  endfunction

  function automatic bit has_header(input logic [7:0] t);
    return (t < 8'd64) && type_mask_q[t[5:0]];
  endfunction

  // Advances the model by one received byte; give is set when a beat is due.
  task automatic deframe_byte(input logic [7:0] b, output bit give,
                              output cdf_pkg::result_t r);
    int n;
    logic [31:0] m;
    give = 1'b0;
    r = '0;
    r.query_type = cur_type;
    case (parse_phase)
      cdf_pkg::PH_TYPE: begin
        cur_type = b;
        if (has_header(b)) begin
          parse_phase = cdf_pkg::PH_CTRL;
        end else begin
          give = 1'b1;
          r.kind = cdf_pkg::KIND_SHORT;
          r.query_type = b;
          parse_phase = cdf_pkg::PH_HUNT;
          hunt_window = '0;
          hunt_fill = '0;
        end
      end
      cdf_pkg::PH_CTRL: begin
        frag_flags = b[1:0];
        hdr_count = '0;
        if (!b[cdf_pkg::CTRL_CONT_BIT]) begin
          running_crc = cdf_pkg::CRC_INIT;
          parse_phase = cdf_pkg::PH_HDR;
        end else begin
          parse_phase = cdf_pkg::PH_LEN;
        end
      end
      cdf_pkg::PH_HDR: begin
        if (hdr_count >= cdf_pkg::HDR_CRC_START)
          header_crc[8 * (hdr_count - cdf_pkg::HDR_CRC_START) +: 8] = b;
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= cdf_pkg::HDR_BYTES) begin
          hdr_count = '0;
          parse_phase = cdf_pkg::PH_LEN;
        end
      end
      cdf_pkg::PH_LEN: begin
        if (hdr_count == 4'd0) begin
          payload_left = {8'd0, b};
          hdr_count = 4'd1;
        end else begin
          payload_left[15:8] = b;
          hdr_count = '0;
          if (payload_left != 16'd0) begin
            parse_phase = cdf_pkg::PH_DATA;
          end else begin
            parse_phase = cdf_pkg::PH_HUNT;
            hunt_window = '0;
            hunt_fill = '0;
            if (frag_flags[cdf_pkg::CTRL_LAST_BIT]) begin
              give = 1'b1;
              r.kind = cdf_pkg::KIND_EMPTY_END;
              r.first_fragment = !frag_flags[cdf_pkg::CTRL_CONT_BIT];
              r.end_of_message = 1'b1;
              r.crc_ok = (~running_crc == header_crc);
            end
          end
        end
      end
      cdf_pkg::PH_DATA: begin
        running_crc = crc_update(running_crc, b);
        payload_left = payload_left - 16'd1;
        give = 1'b1;
        r.kind = cdf_pkg::KIND_DATA;
        r.data_byte = b;
        r.first_fragment = !frag_flags[cdf_pkg::CTRL_CONT_BIT];
        r.end_of_message = (payload_left == 16'd0) && frag_flags[cdf_pkg::CTRL_LAST_BIT];
        r.crc_ok = r.end_of_message && (~running_crc == header_crc);
        if (payload_left == 16'd0) begin
          parse_phase = cdf_pkg::PH_HUNT;
          hunt_window = '0;
          hunt_fill = '0;
        end
      end
      default: begin
        n = marker_bytes();
        m = (n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
        hunt_window = {hunt_window[23:0], b};
        if (hunt_fill < 3'd4) hunt_fill = hunt_fill + 3'd1;
        if (int'(hunt_fill) >= n && (hunt_window & m) == (marker_value_q & m)) begin
          hunt_window = '0;
          hunt_fill = '0;
          parse_phase = cdf_pkg::PH_TYPE;
        end else begin
          parse_phase = cdf_pkg::PH_HUNT;
        end
      end
    endcase
  endtask

  // Offers one byte and waits until it is taken. Valid is left high so that
  // back-to-back beats need no second assignment in the same step.
  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input cdf_pkg::result_t want = '0);
    bit give;
    cdf_pkg::result_t r;
    if (!calm && $urandom_range(99, 0) < 21) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b, give, r);
    if (give) deframed_due.push_back(typed ? want : r);
  endtask

  task automatic feed(input logic [7:0] b);
    push_byte(b);
    random_items++;
  endtask

  // Waits until every predicted beat has come back, plus the pipeline depth
  // for bytes that make no beat.
  task automatic drain_deframer();
    s_tvalid <= 1'b0;
    while (deframed_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] mv, input logic [2:0] ml,
                              input logic [63:0] tm);
    logic [63:0] vals [3];
    logic [1:0]  idxs [3];
    idxs = '{cdf_pkg::REG_MARKER_VALUE, cdf_pkg::REG_MARKER_LEN, cdf_pkg::REG_TYPE_MASK};
    vals = '{{32'd0, mv}, {61'd0, ml}, tm};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idxs[i])
        cdf_pkg::REG_MARKER_VALUE: marker_value_q = vals[i][31:0];
        cdf_pkg::REG_MARKER_LEN:   marker_len_q = vals[i][2:0];
        default:                   type_mask_q = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_marker();
    for (int k = marker_bytes() - 1; k >= 0; k--) feed(marker_value_q[8 * k +: 8]);
  endtask

  // One message: noise at times, then a headerless query or one or more framed fragments.
  task automatic send_message();
    logic [7:0]  msg [$];
    logic [7:0]  qtype;
    logic [7:0]  ctrl;
    logic [7:0]  upper;
    logic [31:0] crc;
    logic [15:0] frag_len;
    int          total, roll, frag_count, remaining, sent, pos;
    bit          cut;
    if ($urandom_range(99, 0) < 25)
      repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255, 0)));
    qtype = 8'($urandom_range(255, 0));
    if ($urandom_range(99, 0) < 80) begin
      repeat (8) if (!has_header(qtype)) qtype = 8'($urandom_range(63, 0));
    end
    if (!has_header(qtype)) begin
      send_marker();
      feed(qtype);
      return;
    end
    roll = int'($urandom_range(999, 0));
    total = (roll < 5) ? int'($urandom_range(280, 256)) :
            (roll < 200) ? int'($urandom_range(40, 13)) : int'($urandom_range(12, 0));
    crc = cdf_pkg::CRC_INIT;
    for (int k = 0; k < total; k++) begin
      msg.push_back(8'($urandom_range(255, 0)));
      crc = crc_update(crc, msg[k]);
    end
    crc = ~crc;
    if ($urandom_range(9, 0) == 0) crc = crc ^ (32'd1 << $urandom_range(31, 0));
    frag_count = int'($urandom_range(3, 1));
    remaining = total;
    pos = 0;
    for (int f = 0; f < frag_count; f++) begin
      frag_len = (f == frag_count - 1) ? 16'(remaining) :
                 16'($urandom_range(remaining, 0));
      remaining -= int'(frag_len);
      upper = 8'($urandom_range(255, 0));
      ctrl = {upper[7:2], f == frag_count - 1, f != 0};
      // A scrambled control byte now and then.
      if ($urandom_range(19, 0) == 0) ctrl = upper;
      send_marker();
      feed(qtype);
      feed(ctrl);
      if (!ctrl[cdf_pkg::CTRL_CONT_BIT]) begin
        repeat (8) feed(8'($urandom_range(255, 0)));
        for (int k = 0; k < 4; k++) feed(crc[8 * k +: 8]);
      end
      feed(frag_len[7:0]);
      feed(frag_len[15:8]);
      cut = ($urandom_range(32, 0) == 0);
      sent = cut ? int'($urandom_range(frag_len, 0)) : int'(frag_len);
      for (int k = 0; k < sent; k++) feed(msg[pos + k]);
      pos += int'(frag_len);
      if (cut) return;
    end
  endtask

  function automatic script_row_t byte_row(input logic [7:0] b);
    script_row_t row;
    row = '{default: '0};
    row.rx = b;
    return row;
  endfunction

  function automatic script_row_t want_row(input logic [7:0] b, input cdf_pkg::kind_t k,
                                           input logic [7:0] qt, input logic [7:0] db,
                                           input logic ff, input logic eom, input logic ok);
    script_row_t row;
    row = byte_row(b);
    row.has_want = 1'b1;
    row.want = '{kind: k, query_type: qt, data_byte: db, first_fragment: ff,
                 end_of_message: eom, crc_ok: ok};
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [31:0] mv, input logic [2:0] ml,
                                          input logic [63:0] tm);
    script_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.mv = mv;
    row.ml = ml;
    row.tm = tm;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    cdf_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (deframed_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got kind %0h type %0h data %0h",
                 $time, m_tuser, m_tdata[7:0], m_tdata[15:8]);
        mismatch_count++;
      end else begin
        want = deframed_due.pop_front();
        check_field("result_kind", 8'(want.kind), 8'(m_tuser));
        check_field("query_type", want.query_type, m_tdata[7:0]);
        check_field("data_byte", want.data_byte, m_tdata[15:8]);
        check_field("first_fragment", 8'(want.first_fragment), 8'(m_tdata[16]));
        check_field("end_of_message", 8'(want.end_of_message), 8'(m_tlast));
        check_field("crc_ok", 8'(want.crc_ok), 8'(m_tdata[17]));
      end
    end
  end

  // Output side: random stalls, calm windows, and two long hold-offs while
  // the input keeps offering bytes.
  initial begin
    int hold_left;
    int sink_ticks;
    hold_left = 0;
    sink_ticks = 0;
    forever begin
      @(posedge clk);
      sink_ticks++;
      if (sink_ticks == 800 || sink_ticks == 2500) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= 21);
      end
    end
  end

  initial begin
    int round;
    int since;
    logic [31:0] mv;
    logic [2:0]  ml;
    logic [63:0] tm;

    // Reset settings: marker 0x00 of one byte, every type headerless.
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'h00));
    script.push_back(want_row(8'hFF, cdf_pkg::KIND_SHORT, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0));
    // A zero marker length acts as one byte.
    script.push_back(cfg_row(32'h0000_00A5, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    script.push_back(byte_row(8'hA5));
    script.push_back(want_row(8'h40, cdf_pkg::KIND_SHORT, 8'h40, 8'h00, 1'b0, 1'b0, 1'b0));
    // Empty continuation, not last: nothing comes out.
    script.push_back(byte_row(8'hA5));
    script.push_back(byte_row(8'h3F));
    script.push_back(byte_row(8'h01));
    script.push_back(byte_row(8'h00));
    script.push_back(byte_row(8'h00));
    // Empty last continuation: the CRC state from reset matches a zero CRC.
    script.push_back(byte_row(8'hA5));
    script.push_back(byte_row(8'h3F));
    script.push_back(byte_row(8'h03));
    script.push_back(byte_row(8'h00));
    script.push_back(want_row(8'h00, cdf_pkg::KIND_EMPTY_END, 8'h3F, 8'h00,
                              1'b0, 1'b1, 1'b1));
    // One payload byte in a continuation that is not last.
    script.push_back(byte_row(8'hA5));
    script.push_back(byte_row(8'h3F));
    script.push_back(byte_row(8'h01));
    script.push_back(byte_row(8'h01));
    script.push_back(byte_row(8'h00));
    script.push_back(want_row(8'hFF, cdf_pkg::KIND_DATA, 8'h3F, 8'hFF, 1'b0, 1'b0, 1'b0));
    // Length above four saturates; a broken marker prefix is skipped.
    script.push_back(cfg_row(32'hFFFF_FFFF, 3'd7, 64'd0));
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'h00));
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'hFF));
    script.push_back(want_row(8'h00, cdf_pkg::KIND_SHORT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain_deframer();
        write_config(script[i].mv, script[i].ml, script[i].tm);
      end else begin
        push_byte(script[i].rx, script[i].has_want, script[i].want);
      end
    end

    round = 0;
    while (random_items < RANDOM_BYTES) begin
      drain_deframer();
      case (round)
        0: begin
          mv = 32'd0;
          ml = 3'd1;
          tm = '1;
        end
        1: begin
          mv = 32'hFFFF_FFFF;
          ml = 3'd4;
          tm = '1;
        end
        2: begin
          mv = $urandom;
          ml = 3'd0;
          tm = {$urandom, $urandom};
        end
        3: begin
          mv = $urandom;
          ml = 3'd7;
          tm = 64'd0;
        end
        default: begin
          mv = $urandom;
          ml = 3'($urandom_range(7, 0));
          tm = {$urandom, $urandom} | {$urandom, $urandom};
        end
      endcase
      write_config(mv, ml, tm);
      round++;
      since = random_items;
      while (random_items - since < 160 && random_items < RANDOM_BYTES) send_message();
    end

    drain_deframer();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
